// ===== hw/rtl/shtc_pkg.sv =====
// ============================================================================
// shtc_pkg
// Shared widths, constants and types of the strip hit cluster finder.
// ============================================================================
package shtc_pkg;

    localparam int MaxHitsDefault = 64;
    localparam int CfgIdxW        = 2;
    localparam int CfgDataW       = 20;
    localparam int EnergyW        = 20;
    localparam int SumW           = 26;
    localparam int CountW         = 7;
    localparam int KeyW           = 11;
    localparam int ChanW          = 10;
    localparam int PosW           = 24;
    localparam int ExtW           = 23;
    localparam int PayW           = 3 * PosW + 3 * ExtW;

    localparam logic [SumW-1:0]   SumMax   = 26'h3FFFFFF;
    localparam logic [CountW-1:0] CountMax = 7'h7F;

    localparam logic [CfgIdxW-1:0] RegSiLow   = 2'd0;
    localparam logic [CfgIdxW-1:0] RegSiHigh  = 2'd1;
    localparam logic [CfgIdxW-1:0] RegCdLow   = 2'd2;
    localparam logic [CfgIdxW-1:0] RegCdHigh  = 2'd3;

    localparam logic [1:0] MatSi     = 2'd0;
    localparam logic [1:0] MatCdte   = 2'd1;
    localparam logic [1:0] MatOther2 = 2'd2;
    localparam logic [1:0] MatOther3 = 2'd3;

    // One stored hit as it travels through the cell chain
    typedef struct packed {
        logic [KeyW-1:0]    key;
        logic [ChanW-1:0]   chan;
        logic [EnergyW-1:0] energy;
        logic [PayW-1:0]    pay;
    } hit_t;

    // Control from the sequencer to every cell
    typedef struct packed {
        logic load;     // shift a new hit into the chain
        logic rotate;   // rotate the chain by one place
        logic clear;    // drop all hits
        logic unmark;   // drop the member flags of the emitted cluster
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/shtc_cell.sv =====
// ============================================================================
// shtc_cell
// One slot of the hit chain: holds a hit, its remaining and member flags.
// ============================================================================
module shtc_cell
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  shtc_pkg::cell_ctrl_t       ctrl,
    input  shtc_pkg::hit_t             hit_in,
    input  logic                       rem_in,
    input  logic                       mem_in,
    input  logic                       join_in,
    output shtc_pkg::hit_t             hit_out,
    output logic                       rem_out,
    output logic                       mem_out
);

    shtc_pkg::hit_t hit_reg;
    logic           rem_reg;
    logic           mem_reg;

    // Hold payload; shift on load or rotate
    always_ff @(posedge clk)
    begin
        if (ctrl.load || ctrl.rotate)
        begin
            hit_reg <= hit_in;
        end
    end

    // Flags: rotate moves them along, join turns the incoming hit into a
    // member and takes it out of the remaining set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 1'b0;
            mem_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            rem_reg <= 1'b0;
            mem_reg <= 1'b0;
        end
        else if (ctrl.load)
        begin
            rem_reg <= rem_in;
            mem_reg <= 1'b0;
        end
        else if (ctrl.rotate)
        begin
            rem_reg <= rem_in & ~join_in;
            mem_reg <= mem_in | join_in;
        end
        else if (ctrl.unmark)
        begin
            mem_reg <= 1'b0;
        end
    end

    assign hit_out = hit_reg;
    assign rem_out = rem_reg;
    assign mem_out = mem_reg;

endmodule

// ===== hw/rtl/strip_hit_threshold_cluster.sv =====
// ============================================================================
// strip_hit_threshold_cluster
// Threshold filter and cluster finder for strip detector hits of one event.
// ============================================================================
// Usage: each hit is a transaction on start/busy, one per cycle while busy is
// low, with its fields on the hit ports. Silicon and CdTe hits below the
// threshold of their material and side are dropped; other materials always
// pass. Kept hits shift into a chain of MAX_HITS cells; once MAX_HITS are
// held, further hits are ignored. The hit with last_hit set ends the event
// and raises busy from the next cycle. Each cluster takes one full rotation
// of the chain, in which the oldest remaining hit seeds and each later hit
// of the same key with a neighbor channel joins, and is then emitted; busy
// drops in the cycle that shows the final cluster. An event with no kept
// hits gives no result and holds busy for one cycle. Each cluster is on the
// result ports for one cycle with result_valid high; the receiver cannot
// stall. Thresholds are written through cfg_we, cfg_index and cfg_data while
// idle; indexes beyond the list are ignored. Reset clears the chain flags,
// the thresholds and the sequencer state; hit payloads and the cluster key
// and peak registers are not reset.
// ============================================================================
module strip_hit_threshold_cluster
#(
    parameter int MAX_HITS = shtc_pkg::MaxHitsDefault
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [shtc_pkg::CfgIdxW-1:0]      cfg_index,
    input  logic [shtc_pkg::CfgDataW-1:0]     cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic [7:0]                        detector_id,
    input  logic [1:0]                        material,
    input  logic                              voltage_side,
    input  logic [9:0]                        channel,
    input  logic [19:0]                       energy,
    input  logic signed [23:0]                position_x,
    input  logic signed [23:0]                position_y,
    input  logic signed [23:0]                position_z,
    input  logic [22:0]                       extent_x,
    input  logic [22:0]                       extent_y,
    input  logic [22:0]                       extent_z,
    input  logic                              last_hit,
    output logic                              result_valid,
    output logic [7:0]                        cluster_detector,
    output logic [1:0]                        cluster_material,
    output logic                              cluster_side,
    output logic [6:0]                        hit_count,
    output logic [25:0]                       energy_sum,
    output logic signed [23:0]                peak_x,
    output logic signed [23:0]                peak_y,
    output logic signed [23:0]                peak_z,
    output logic [22:0]                       peak_extent_x,
    output logic [22:0]                       peak_extent_y,
    output logic [22:0]                       peak_extent_z,
    output logic                              final_cluster
);

    localparam int IdxW = $clog2(MAX_HITS);
    localparam int TotW = $clog2(MAX_HITS + 1);
    localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_HITS - 1);
    localparam logic [TotW-1:0] FullCnt = TotW'(MAX_HITS);
    localparam logic [shtc_pkg::CountW-1:0] CntOne =
        {{(shtc_pkg::CountW-1){1'b0}}, 1'b1};

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    // ------------------------------------------------------------------
    // Threshold registers
    // ------------------------------------------------------------------
    logic [shtc_pkg::CfgDataW-1:0] thr_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                thr_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                shtc_pkg::RegSiLow:  thr_reg[0] <= cfg_data;
                shtc_pkg::RegSiHigh: thr_reg[1] <= cfg_data;
                shtc_pkg::RegCdLow:  thr_reg[2] <= cfg_data;
                shtc_pkg::RegCdHigh: thr_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    logic pass_thr;
    always_comb
    begin
        case (material)
            shtc_pkg::MatSi:   pass_thr = energy >= thr_reg[{1'b0, voltage_side}];
            shtc_pkg::MatCdte: pass_thr = energy >= thr_reg[{1'b1, voltage_side}];
            default:           pass_thr = 1'b1;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    logic [1:0]                   state_reg, state_next;
    logic [TotW-1:0]              total_reg, total_next;
    logic [IdxW-1:0]              step_reg, step_next;
    logic                         found_reg, found_next;
    logic [shtc_pkg::KeyW-1:0]    key_reg, key_next;
    logic [shtc_pkg::CountW-1:0]  cnt_reg, cnt_next;
    logic [shtc_pkg::SumW-1:0]    sum_reg, sum_next;
    logic [shtc_pkg::EnergyW-1:0] best_reg, best_next;
    logic [shtc_pkg::PayW-1:0]    bpay_reg, bpay_next;
    logic                         out_v_reg, out_v_next;
    logic                         out_f_reg, out_f_next;

    shtc_pkg::cell_ctrl_t ctrl;
    shtc_pkg::hit_t       new_hit;
    shtc_pkg::hit_t       chain_hit [MAX_HITS];
    logic                 chain_rem [MAX_HITS];
    logic                 chain_mem [MAX_HITS];
    logic [MAX_HITS-1:0]  rem_vec;
    logic                 join_head;

    assign new_hit.key    = {voltage_side, material, detector_id};
    assign new_hit.chan   = channel;
    assign new_hit.energy = energy;
    assign new_hit.pay    = {position_x, position_y, position_z,
                             extent_x, extent_y, extent_z};

    // ------------------------------------------------------------------
    // Cell chain: cell 0 is the head; rotate feeds the tail back to the head
    // ------------------------------------------------------------------
    genvar g;
    generate
        for (g = 0; g < MAX_HITS; g++)
        begin : gen_cell
            shtc_pkg::hit_t h_in;
            logic           r_in;
            logic           m_in;
            logic           j_in;
            if (g == 0)
            begin : gen_head
                assign h_in = ctrl.load ? new_hit : chain_hit[MAX_HITS-1];
                assign r_in = ctrl.load ? 1'b1 : chain_rem[MAX_HITS-1];
                assign m_in = chain_mem[MAX_HITS-1];
                assign j_in = join_head;
            end
            else
            begin : gen_body
                assign h_in = chain_hit[g-1];
                assign r_in = chain_rem[g-1];
                assign m_in = chain_mem[g-1];
                assign j_in = 1'b0;
            end
            shtc_cell u_cell
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (ctrl),
                .hit_in  (h_in),
                .rem_in  (r_in),
                .mem_in  (m_in),
                .join_in (j_in),
                .hit_out (chain_hit[g]),
                .rem_out (chain_rem[g]),
                .mem_out (chain_mem[g])
            );
            assign rem_vec[g] = chain_rem[g];
        end
    endgenerate

    // Hits enter at the head, so the oldest stored hit sits at cell total-1
    // and unused cells above it carry no flags. One rotation of MAX_HITS
    // steps from this position passes every hit over the tail in arrival
    // order and brings the chain back to it.

    // Neighbor test: tail hit against all members by channel +/- 1
    logic [MAX_HITS-1:0] adj_vec;
    shtc_pkg::hit_t      tail;
    assign tail = chain_hit[MAX_HITS-1];
    always_comb
    begin
        for (int i = 0; i < MAX_HITS; i++)
        begin
            adj_vec[i] = chain_mem[i]
                && ((chain_hit[i].chan == tail.chan + 10'd1 && tail.chan != 10'h3FF)
                 || (tail.chan == chain_hit[i].chan + 10'd1
                     && chain_hit[i].chan != 10'h3FF));
        end
    end

    // First remaining hit seeds; later ones join on same key and a neighbor
    assign join_head = (state_reg == ST_SCAN) && chain_rem[MAX_HITS-1]
                       && !chain_mem[MAX_HITS-1]
                       && (!found_reg || ((tail.key == key_reg) && (|adj_vec)));

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic accept;
    assign accept = start && !busy;
    assign busy   = (state_reg != ST_LOAD);

    logic [shtc_pkg::SumW:0] sum_add;
    assign sum_add = {1'b0, sum_reg} + (shtc_pkg::SumW+1)'(tail.energy);

    always_comb
    begin
        state_next  = state_reg;
        total_next  = total_reg;
        step_next   = step_reg;
        found_next  = found_reg;
        key_next    = key_reg;
        cnt_next    = cnt_reg;
        sum_next    = sum_reg;
        best_next   = best_reg;
        bpay_next   = bpay_reg;
        out_v_next  = 1'b0;
        out_f_next  = 1'b0;
        ctrl        = '0;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (pass_thr && total_reg < FullCnt)
                    begin
                        ctrl.load  = 1'b1;
                        total_next = total_reg + TotW'(1);
                    end
                    if (last_hit)
                    begin
                        state_next = ST_SCAN;
                        step_next  = '0;
                        found_next = 1'b0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!found_reg && !(|rem_vec))
                begin
                    // nothing stored: end the event without a result
                    ctrl.clear = 1'b1;
                    total_next = '0;
                    state_next = ST_LOAD;
                end
                else
                begin
                    ctrl.rotate = 1'b1;
                    // accumulate each member as it joins, in stored order
                    if (join_head)
                    begin
                        found_next = 1'b1;
                        if (!found_reg)
                        begin
                            key_next  = tail.key;
                            cnt_next  = CntOne;
                            sum_next  = {{(shtc_pkg::SumW-shtc_pkg::EnergyW){1'b0}},
                                         tail.energy};
                            best_next = tail.energy;
                            bpay_next = tail.pay;
                        end
                        else
                        begin
                            if (cnt_reg != shtc_pkg::CountMax)
                            begin
                                cnt_next = cnt_reg + CntOne;
                            end
                            sum_next = sum_add[shtc_pkg::SumW] ? shtc_pkg::SumMax
                                                               : sum_add[shtc_pkg::SumW-1:0];
                            if (tail.energy > best_reg)
                            begin
                                best_next = tail.energy;
                                bpay_next = tail.pay;
                            end
                        end
                    end
                    if (step_reg == LastIdx)
                    begin
                        step_next  = '0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        step_next = step_reg + IdxW'(1);
                    end
                end
            end
            ST_EMIT:
            begin
                out_v_next  = 1'b1;
                out_f_next  = !(|rem_vec);
                ctrl.unmark = 1'b1;
                found_next  = 1'b0;
                step_next   = '0;
                if (!(|rem_vec))
                begin
                    ctrl.clear = 1'b1;
                    total_next = '0;
                    state_next = ST_LOAD;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            total_reg  <= '0;
            step_reg   <= '0;
            found_reg  <= 1'b0;
            out_v_reg  <= 1'b0;
            out_f_reg  <= 1'b0;
            cnt_reg    <= '0;
            sum_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            total_reg  <= total_next;
            step_reg   <= step_next;
            found_reg  <= found_next;
            out_v_reg  <= out_v_next;
            out_f_reg  <= out_f_next;
            cnt_reg    <= cnt_next;
            sum_reg    <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        best_reg <= best_next;
        bpay_reg <= bpay_next;
    end

    // ------------------------------------------------------------------
    // Result ports
    // ------------------------------------------------------------------
    assign result_valid     = out_v_reg;
    assign final_cluster    = out_f_reg;
    assign cluster_detector = key_reg[7:0];
    assign cluster_material = key_reg[9:8];
    assign cluster_side     = key_reg[10];
    assign hit_count        = cnt_reg;
    assign energy_sum       = sum_reg;
    assign peak_x           = bpay_reg[shtc_pkg::PayW-1 -: 24];
    assign peak_y           = bpay_reg[shtc_pkg::PayW-25 -: 24];
    assign peak_z           = bpay_reg[shtc_pkg::PayW-49 -: 24];
    assign peak_extent_x    = bpay_reg[68:46];
    assign peak_extent_y    = bpay_reg[45:23];
    assign peak_extent_z    = bpay_reg[22:0];

endmodule
